/* hdl/timed_callback_scheduler_macros.svh */
// Assertion macros for the timed callback scheduler
`ifndef TIMED_CALLBACK_SCHEDULER_MACROS_SVH
`define TIMED_CALLBACK_SCHEDULER_MACROS_SVH
`define TCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/tcs_pkg.sv */
`default_nettype none
package tcs_pkg;
  localparam logic [2:0] CMD_ADD_TIMED    = 3'd0;
  localparam logic [2:0] CMD_ADD_REPEATED = 3'd1;
  localparam logic [2:0] CMD_CHANGE       = 3'd2;
  localparam logic [2:0] CMD_REMOVE       = 3'd3;
  localparam logic [2:0] CMD_CLEAR        = 3'd4;
  localparam logic [2:0] CMD_PROCESS      = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ARG   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic signed [63:0] DUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [63:0] time_req;
    logic [62:0]        interval;
    logic [63:0]        callback_id;
    logic [31:0]        handle;
  } tcs_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        entry_id;
    logic               fired;
    logic [31:0]        fired_handle;
    logic signed [63:0] next_due;
    logic               last;
  } tcs_out_t;

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic [62:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {2'b00, b};
    if (!s[64] && s[63]) return DUE_MAX;
    return s[63:0];
  endfunction
endpackage
`default_nettype wire

/* hdl/tcs_table.sv */
`default_nettype none
module tcs_table import tcs_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int IW = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [IW-1:0]     rd_idx,
  output logic                   rd_valid,
  output logic signed [63:0]     rd_due,
  output logic [62:0]            rd_period,
  output logic                   rd_rep,
  output logic [63:0]            rd_ident,
  output logic [31:0]            rd_handle,
  input  wire logic              wr_en,
  input  wire logic [IW-1:0]     wr_idx,
  input  wire logic              wr_valid,
  input  wire logic              wr_all,
  input  wire logic signed [63:0] wr_due,
  input  wire logic [62:0]       wr_period,
  input  wire logic              wr_rep,
  input  wire logic [63:0]       wr_ident,
  input  wire logic [31:0]       wr_handle,
  input  wire logic              clr_all
);
  logic [ENTRIES-1:0]        valid_r;
  logic signed [63:0]        due_r    [ENTRIES];
  logic [62:0]               period_r [ENTRIES];
  logic [ENTRIES-1:0]        rep_r;
  logic [63:0]               ident_r  [ENTRIES];
  logic [31:0]               handle_r [ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr_all) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_all) begin
      due_r[wr_idx]    <= wr_due;
      period_r[wr_idx] <= wr_period;
      rep_r[wr_idx]    <= wr_rep;
      ident_r[wr_idx]  <= wr_ident;
      handle_r[wr_idx] <= wr_handle;
    end else if (wr_en && wr_valid) begin
      due_r[wr_idx]    <= wr_due;
      period_r[wr_idx] <= wr_period;
    end
  end

  assign rd_valid  = valid_r[rd_idx];
  assign rd_due    = due_r[rd_idx];
  assign rd_period = period_r[rd_idx];
  assign rd_rep    = rep_r[rd_idx];
  assign rd_ident  = ident_r[rd_idx];
  assign rd_handle = handle_r[rd_idx];
endmodule
`default_nettype wire

/* hdl/timed_callback_scheduler.sv */
`default_nettype none
// Add, change, remove, clear and unknown commands run from acceptance to the final result
// as a lookup scan, the action state, the setup state and a scan for the earliest due
// time, all through the one table read port.
// Process: a scan and a fire step per fired entry, then setup and the final scan, plus out_ready stalls.
// Throughput: one item at a time; the next is accepted once the final result is registered.
// Reset: rst_n synchronous, clears every slot valid bit, the id counter and control.
module timed_callback_scheduler import tcs_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire tcs_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output tcs_out_t      out_data
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_FIRE, S_FINAL, S_OUT} state_t;

  state_t            state_r;
  tcs_in_t           req_r;
  logic [CW-1:0]     idx_r;
  logic [ENTRIES-1:0] done_r;
  logic              hit_r;
  logic [IW-1:0]     hit_idx_r;
  logic signed [63:0] best_r;
  logic              free_r;
  logic [IW-1:0]     free_idx_r;
  logic [63:0]       id_src_r;
  logic              final_r;
  logic [1:0]        status_r;
  logic [63:0]       new_id_r;
  tcs_out_t          out_r;
  logic              out_valid_r;

  logic              rd_valid, rd_rep;
  logic signed [63:0] rd_due;
  logic [62:0]       rd_period;
  logic [63:0]       rd_ident;
  logic [31:0]       rd_handle;
  logic [IW-1:0]     rd_idx;
  logic              wr_en, wr_valid, wr_all, clr_all;
  logic [IW-1:0]     wr_idx;
  logic signed [63:0] wr_due;
  logic [62:0]       wr_period;
  logic              wr_rep;
  logic [63:0]       wr_ident;
  logic [31:0]       wr_handle;

  logic              bad_add;
  logic signed [63:0] rep_due;
  logic signed [63:0] inc_now;

  assign bad_add = ((req_r.command == CMD_ADD_REPEATED) && (req_r.interval == '0))
                   || (req_r.handle == '0);
  assign rd_idx  = (state_r == S_SCAN) ? idx_r[IW-1:0] : hit_idx_r;
  assign rep_due = add_sat(rd_due, rd_period);
  assign inc_now = (req_r.time_req == DUE_MAX) ? DUE_MAX : req_r.time_req + 64'sd1;

  tcs_table #(.ENTRIES(ENTRIES), .IW(IW)) u_table (
    .clk, .rst_n, .rd_idx, .rd_valid, .rd_due, .rd_period, .rd_rep, .rd_ident,
    .rd_handle, .wr_en, .wr_idx, .wr_valid, .wr_all, .wr_due, .wr_period,
    .wr_rep, .wr_ident, .wr_handle, .clr_all
  );

  always_comb begin
    wr_en = 1'b0; wr_idx = hit_idx_r; wr_valid = 1'b1; wr_all = 1'b0;
    wr_due = rep_due; wr_period = rd_period; wr_rep = rd_rep;
    wr_ident = id_src_r + 64'd1; wr_handle = req_r.handle;
    clr_all = 1'b0;
    if (state_r == S_ACT) begin
      unique case (req_r.command)
        CMD_ADD_TIMED, CMD_ADD_REPEATED: begin
          wr_en = !bad_add && free_r; wr_idx = free_idx_r; wr_all = 1'b1;
          wr_rep = (req_r.command == CMD_ADD_REPEATED);
          wr_period = wr_rep ? req_r.interval : '0;
          wr_due = wr_rep ? add_sat(req_r.time_req, req_r.interval) : req_r.time_req;
        end
        CMD_CHANGE: begin
          wr_en = (req_r.interval != '0) && hit_r;
          wr_period = req_r.interval;
          wr_due = add_sat(req_r.time_req, req_r.interval);
        end
        CMD_REMOVE: begin
          wr_en = hit_r; wr_valid = 1'b0;
        end
        CMD_CLEAR: clr_all = 1'b1;
        default: ;
      endcase
    end else if (state_r == S_FIRE && !out_valid_r) begin
      wr_en = 1'b1; wr_valid = rd_rep;
      wr_due = (rep_due < req_r.time_req) ? inc_now : rep_due;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      id_src_r    <= '0;
      final_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            idx_r   <= '0;
            hit_r   <= 1'b0;
            free_r  <= 1'b0;
            done_r  <= '0;
            best_r  <= DUE_MAX;
            final_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_r == CW'(ENTRIES)) begin
            state_r <= final_r ? S_OUT
                     : (req_r.command == CMD_PROCESS) ? (hit_r ? S_FIRE : S_FINAL)
                     : S_ACT;
          end else begin
            idx_r <= idx_r + CW'(1);
            if (final_r || (req_r.command == CMD_PROCESS)) begin
              if (rd_valid && rd_due < best_r
                  && (final_r || (!done_r[idx_r[IW-1:0]] && rd_due <= req_r.time_req))) begin
                best_r <= rd_due; hit_r <= 1'b1; hit_idx_r <= idx_r[IW-1:0];
              end else if (!final_r && rd_valid && !done_r[idx_r[IW-1:0]] && !hit_r
                           && rd_due == DUE_MAX && req_r.time_req == DUE_MAX) begin
                hit_r <= 1'b1; hit_idx_r <= idx_r[IW-1:0]; best_r <= rd_due;
              end
            end else begin
              if (!rd_valid && !free_r) begin
                free_r <= 1'b1; free_idx_r <= idx_r[IW-1:0];
              end
              if (rd_valid && !hit_r && rd_ident == req_r.callback_id) begin
                hit_r <= 1'b1; hit_idx_r <= idx_r[IW-1:0];
              end
            end
          end
        end
        S_ACT: begin
          new_id_r <= '0;
          status_r <= ST_OK;
          unique case (req_r.command)
            CMD_ADD_TIMED, CMD_ADD_REPEATED: begin
              if (bad_add) status_r <= ST_BAD_ARG;
              else if (!free_r) status_r <= ST_FULL;
              else begin
                id_src_r <= id_src_r + 64'd1;
                new_id_r <= id_src_r + 64'd1;
              end
            end
            CMD_CHANGE: begin
              if (req_r.interval == '0) status_r <= ST_BAD_ARG;
              else if (!hit_r) status_r <= ST_NOT_FOUND;
            end
            CMD_REMOVE: if (!hit_r) status_r <= ST_NOT_FOUND;
            CMD_CLEAR: ;
            default: status_r <= ST_BAD_ARG;
          endcase
          state_r <= S_FINAL;
        end
        S_FIRE: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_r <= '{status: ST_OK, entry_id: rd_ident, fired: 1'b1,
                       fired_handle: rd_handle, next_due: '0, last: 1'b0};
            done_r[hit_idx_r] <= 1'b1;
            idx_r <= '0; hit_r <= 1'b0; best_r <= DUE_MAX;
            state_r <= S_SCAN;
          end
        end
        S_FINAL: begin
          if (req_r.command == CMD_PROCESS) begin
            status_r <= ST_OK; new_id_r <= '0;
          end
          final_r <= 1'b1; idx_r <= '0; best_r <= DUE_MAX; hit_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_r <= '{status: status_r, entry_id: new_id_r, fired: 1'b0,
                       fired_handle: '0, next_due: best_r, last: 1'b1};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

/* hdl/tcs_checker.sv */
`default_nettype none
`include "timed_callback_scheduler_macros.svh"
module tcs_checker import tcs_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire tcs_out_t out_data
);
  `TCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped while stalled")
  `TCS_ASSERT_IMPL(a_fired_fields, clk, rst_n, out_valid && out_data.fired, !out_data.last && out_data.status == ST_OK, "fired result malformed")
  `TCS_ASSERT_IMPL(a_final_fields, clk, rst_n, out_valid && out_data.last, !out_data.fired && out_data.fired_handle == '0, "final result malformed")
  `TCS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "accepted a second transaction while busy")
endmodule

bind timed_callback_scheduler tcs_checker u_tcs_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
